@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files that check themselves (used by the top level)
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tsa_pkg.sv @@
// shared types, constants and helpers for the typed slot allocator
// no dependencies
package tsa_pkg;

  localparam int DIR_SLOTS   = 8;
  localparam int POINT_SLOTS = 32;
  localparam int SPOT_SLOTS  = 32;
  localparam int TOTAL_SLOTS = DIR_SLOTS + POINT_SLOTS + SPOT_SLOTS;

  localparam int POOL_MAX  = 32;
  localparam int IDX_W     = 5;
  localparam int SIZE_W    = IDX_W + 1;
  localparam int GLOBAL_W  = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SWAP    = 2'd2,
    OP_SET_EN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TYPE_DIR     = 2'd0,
    TYPE_POINT   = 2'd1,
    TYPE_SPOT    = 2'd2,
    TYPE_INVALID = 2'd3
  } light_type_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic             component_on;
    logic [IDX_W-1:0] slot_index;
    light_type_t      prev_type;
    light_type_t      light_type;
    op_t              op;
  } req_t;

  typedef struct packed {
    logic                pad;
    logic                error;
    logic                lit;
    logic [GLOBAL_W-1:0] global_slot;
    logic [IDX_W-1:0]    slot;
    logic                granted;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  function automatic logic [SIZE_W-1:0] pool_size(light_type_t t);
    logic [SIZE_W-1:0] s;
    unique case (t)
      TYPE_DIR:   s = SIZE_W'(DIR_SLOTS);
      TYPE_POINT: s = SIZE_W'(POINT_SLOTS);
      TYPE_SPOT:  s = SIZE_W'(SPOT_SLOTS);
      default:    s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [GLOBAL_W-1:0] pool_base(light_type_t t);
    logic [GLOBAL_W-1:0] b;
    unique case (t)
      TYPE_POINT: b = GLOBAL_W'(DIR_SLOTS);
      TYPE_SPOT:  b = GLOBAL_W'(DIR_SLOTS + POINT_SLOTS);
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/tsa_ctrl.sv @@
// controller: input/output handshakes and the command sequence
// depends on tsa_pkg
module tsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output tsa_pkg::dp_cmd_t cmd
);
  import tsa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free    = !out_valid || m_tready;
  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = out_valid;
  assign cmd.capture = s_tready && s_tvalid;
  assign cmd.execute = (state == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
          if (m_tready) out_valid <= 1'b0;
        end
        ST_EXEC: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/tsa_datapath.sv @@
// datapath: request register, slot bitmaps, first-free search, result register
// depends on tsa_pkg
module tsa_datapath (
  input  logic             clk,
  input  logic             rst,
  input  tsa_pkg::dp_cmd_t cmd,
  input  tsa_pkg::req_t    req_in,
  output tsa_pkg::rsp_t    rsp
);
  import tsa_pkg::*;

  req_t                   req;
  logic [TOTAL_SLOTS-1:0] owned;
  logic [TOTAL_SLOTS-1:0] enabled;
  logic [TOTAL_SLOTS-1:0] owned_next;
  logic [TOTAL_SLOTS-1:0] enabled_next;
  rsp_t                   rsp_next;

  logic [POOL_MAX-1:0] dir_map;
  logic [POOL_MAX-1:0] point_map;
  logic [POOL_MAX-1:0] spot_map;
  logic [POOL_MAX-1:0] pool_map;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic                ty_bad;
  logic                prev_ok;
  logic                ty_ok;
  logic [GLOBAL_W-1:0] prev_g;
  logic [GLOBAL_W-1:0] ty_g;
  logic [GLOBAL_W-1:0] free_g;

  // slots past the end of a pool read as owned
  for (genvar i = 0; i < POOL_MAX; i++) begin : g_map
    if (i < DIR_SLOTS) begin : g_dir
      assign dir_map[i] = owned[i];
    end else begin : g_dir_pad
      assign dir_map[i] = 1'b1;
    end
    if (i < POINT_SLOTS) begin : g_point
      assign point_map[i] = owned[DIR_SLOTS + i];
    end else begin : g_point_pad
      assign point_map[i] = 1'b1;
    end
    if (i < SPOT_SLOTS) begin : g_spot
      assign spot_map[i] = owned[DIR_SLOTS + POINT_SLOTS + i];
    end else begin : g_spot_pad
      assign spot_map[i] = 1'b1;
    end
  end

  always_comb begin
    unique case (req.light_type)
      TYPE_DIR:   pool_map = dir_map;
      TYPE_POINT: pool_map = point_map;
      TYPE_SPOT:  pool_map = spot_map;
      default:    pool_map = '1;
    endcase
  end

  // priority encoder, lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_MAX - 1; i >= 0; i--) begin
      if (!pool_map[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign ty_bad  = (req.light_type == TYPE_INVALID);
  assign prev_ok = (req.prev_type != TYPE_INVALID) &&
                   ({1'b0, req.slot_index} < pool_size(req.prev_type));
  assign ty_ok   = !ty_bad && ({1'b0, req.slot_index} < pool_size(req.light_type));
  assign prev_g  = pool_base(req.prev_type) + {2'b00, req.slot_index};
  assign ty_g    = pool_base(req.light_type) + {2'b00, req.slot_index};
  assign free_g  = pool_base(req.light_type) + {2'b00, free_idx};

  always_comb begin
    owned_next   = owned;
    enabled_next = enabled;
    rsp_next     = '0;
    unique case (req.op)
      OP_ACQUIRE: begin
        if (ty_bad) begin
          rsp_next.error = 1'b1;
        end else if (free_found) begin
          owned_next[free_g]   = 1'b1;
          rsp_next.granted     = 1'b1;
          rsp_next.slot        = free_idx;
          rsp_next.global_slot = free_g;
          rsp_next.lit         = enabled[free_g];
        end
      end
      OP_RELEASE: begin
        if (!prev_ok) begin
          rsp_next.error = 1'b1;
        end else begin
          owned_next[prev_g]   = 1'b0;
          rsp_next.slot        = req.slot_index;
          rsp_next.global_slot = prev_g;
        end
      end
      OP_SWAP: begin
        if (ty_bad || !prev_ok) begin
          rsp_next.error = 1'b1;
        end else if (req.light_type == req.prev_type) begin
          rsp_next.granted     = 1'b1;
          rsp_next.slot        = req.slot_index;
          rsp_next.global_slot = prev_g;
          rsp_next.lit         = owned[prev_g] && enabled[prev_g];
        end else begin
          // pools differ, so the release never touches the searched pool
          owned_next[prev_g] = 1'b0;
          if (free_found) begin
            owned_next[free_g]   = 1'b1;
            rsp_next.granted     = 1'b1;
            rsp_next.slot        = free_idx;
            rsp_next.global_slot = free_g;
            rsp_next.lit         = enabled[free_g];
          end
        end
      end
      OP_SET_EN: begin
        if (!ty_ok) begin
          rsp_next.error = 1'b1;
        end else begin
          enabled_next[ty_g]   = req.component_on;
          rsp_next.slot        = req.slot_index;
          rsp_next.global_slot = ty_g;
          rsp_next.lit         = owned[ty_g] && req.component_on;
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owned   <= '0;
      enabled <= '0;
    end else if (cmd.execute) begin
      owned   <= owned_next;
      enabled <= enabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= req_in;
    if (cmd.execute) rsp <= rsp_next;
  end

endmodule

@@ hdl/typed_slot_allocator_top.sv @@
// Typed slot allocator. Three pools of slots (8 directional, 32 point, 32 spot)
// each slot with an owned bit and an enabled bit, all clear after reset. One
// request item in gives one result item out. An item is taken in the cycle it
// arrives while the block is idle, worked in the execute state (lowest-free-slot
// search and bitmap update happen together), and the result is held in an
// output register; the next item is taken while that result still waits.
// No new item is taken until the current one is executed, following the
// capture-then-execute controller sequence; a stalled output holds the execute step.
// depends on tsa_pkg, tsa_ctrl, tsa_datapath, assert_macros.svh
`include "assert_macros.svh"

module typed_slot_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // op[1:0], light_type[3:2], prev_type[5:4], slot_index[10:6], component_on[11]
  input  logic [tsa_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // granted[0], slot[5:1], global_slot[12:6], lit[13], error[14]
  output logic [tsa_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tsa_pkg::*;

  dp_cmd_t cmd;
  req_t    req_in;
  rsp_t    rsp;

  assign req_in  = req_t'(s_tdata);
  assign m_tdata = OUT_DATA_W'(rsp);

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tsa_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req_in (req_in),
    .rsp    (rsp)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `ASSERT_SAME(a_exec_needs_room, clk, rst, cmd.execute, !m_tvalid || m_tready, "result overwritten")
  `ASSERT_SAME(a_error_clean, clk, rst, m_tvalid && rsp.error, !rsp.granted && !rsp.lit && rsp.global_slot == '0, "error result not cleared")
  `ASSERT_SAME(a_global_range, clk, rst, m_tvalid, rsp.global_slot < GLOBAL_W'(TOTAL_SLOTS), "global slot out of range")

endmodule
